/* hw/rtl/sfrm_pkg.sv */
// sfrm_pkg: shared types and constants for the stereo fade/ramp/mute block.
// No dependencies.
package sfrm_pkg;

  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FADE_UP   = 2'd0,
    REG_FADE_DOWN = 2'd1,
    REG_SILENT    = 2'd2,
    REG_HOLD      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    FUNC_SAMPLE    = 2'd0,
    FUNC_FADE_UP   = 2'd1,
    FUNC_FADE_DOWN = 2'd2,
    FUNC_NONE      = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    MODE_OFF       = 3'd0,
    MODE_UP_DEAD   = 3'd1,
    MODE_UP        = 3'd2,
    MODE_DOWN      = 3'd3,
    MODE_DOWN_DEAD = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ACT_ZERO  = 2'd0,
    ACT_PASS  = 2'd1,
    ACT_SCALE = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_MUL  = 3'd1,
    S_DIV  = 3'd2,
    S_FIN  = 3'd3,
    S_DONE = 3'd4
  } fsm_t;

endpackage

/* hw/rtl/stereo_fade_ramp_mute.sv */
// stereo_fade_ramp_mute: linear fade-in/fade-out with soft mute on a stereo stream.
// Depends on sfrm_pkg. Bit-serial multiply and restoring divide, both lanes in step.
//
// Usage:
//   Input beats carry a func code and a left/right sample pair. func 0 is a
//   sample pair and yields one output beat; func 1 and 2 request a fade up or
//   down and yield nothing; func 3 is ignored.
//   Output beats carry the faded pair and the mode after that pair.
//   Commands are taken in S_IDLE and leave the engine idle. Pairs that pass or
//   mute go through S_DONE to the output register. Pairs on a ramp run a
//   shift-add multiply (S_MUL), then a restoring divide (S_DIV), one quotient
//   bit per cycle, then S_FIN and S_DONE.
//   One item is worked on at a time; in_stall is high while it runs.
//   A finished result sits in the output register while the next item is
//   taken; if the receiver stalls and a second result is ready, the engine
//   holds it and stalls the input until the output register frees up.
//   Reset: mode down_dead (muted), ramp count 0, registers at their defaults.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
module stereo_fade_ramp_mute #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int RAMP_WIDTH   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sfrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfrm_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_func,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_left_in,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_right_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]   out_left_out,
  output logic signed [SAMPLE_WIDTH-1:0]   out_right_out,
  output logic [2:0]                       out_fade_mode
);
  import sfrm_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int RW   = RAMP_WIDTH;
  localparam int NW   = RW + 1;
  localparam int PW   = SW + NW;
  localparam int CmpW = ((RW > CFG_W) ? RW : CFG_W) + 1;
  localparam int CntW = $clog2(PW + 1);

  // config registers
  logic [CFG_W-1:0] fade_up_r, fade_down_r, silent_r;
  logic             hold_r;

  // control state
  fsm_t             state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  logic [RW-1:0]    ramp_r, ramp_nxt;
  logic             out_valid_r;
  logic [CntW-1:0]  cnt_r;

  // datapath
  logic [PW-1:0]    prod_r [2];
  logic [CFG_W-1:0] rem_r  [2];
  logic [SW-1:0]    mag_r  [2];
  logic             neg_r  [2];
  logic [CFG_W-1:0] den_r;
  logic [SW-1:0]    res_r  [2];
  mode_t            res_mode_r;
  logic [SW-1:0]    out_l_r, out_r_r;
  logic [2:0]       out_mode_r;

  logic             in_acc, is_sample, out_free;
  logic             mul_last, div_last;
  act_t             act;
  logic [NW-1:0]    d_num;
  logic [CFG_W-1:0] d_den;
  logic [CmpW-1:0]  n_ext, ramp_ext, v_min;
  logic [SW-1:0]    x_in [2];

  assign x_in[0] = in_left_in;
  assign x_in[1] = in_right_in;

  assign in_acc    = in_valid && !in_stall;
  assign is_sample = (func_t'(in_func) == FUNC_SAMPLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign mul_last  = (cnt_r == CntW'(NW - 1));
  assign div_last  = (cnt_r == CntW'(PW - 1));
  assign ramp_ext  = CmpW'(ramp_r);

  // mode / ramp decision for the beat at the input
  always_comb begin
    mode_nxt = mode_r;
    ramp_nxt = ramp_r;
    act      = ACT_ZERO;
    d_num    = '0;
    d_den    = fade_up_r;
    n_ext    = '0;
    v_min    = (CmpW'(fade_down_r) < ramp_ext) ? CmpW'(fade_down_r) : ramp_ext;
    unique case (func_t'(in_func))
      FUNC_FADE_UP: begin
        if (!hold_r && (mode_r == MODE_DOWN || mode_r == MODE_DOWN_DEAD)) begin
          mode_nxt = MODE_UP_DEAD;
          ramp_nxt = '0;
        end
      end
      FUNC_FADE_DOWN: begin
        if (mode_r != MODE_DOWN && mode_r != MODE_DOWN_DEAD) begin
          if (v_min == '0) begin
            mode_nxt = MODE_DOWN_DEAD;
          end else begin
            mode_nxt = MODE_DOWN;
            ramp_nxt = v_min[RW-1:0];
          end
        end
      end
      FUNC_NONE: begin
      end
      FUNC_SAMPLE: begin
        unique case (mode_r)
          MODE_OFF: begin
            act = ACT_PASS;
          end
          MODE_UP_DEAD, MODE_UP: begin
            n_ext = ramp_ext + CmpW'(1);
            if (mode_r == MODE_UP_DEAD && n_ext <= CmpW'(silent_r)) begin
              ramp_nxt = n_ext[RW-1:0];
              act      = ACT_ZERO;
            end else begin
              if (mode_r == MODE_UP_DEAD) begin
                n_ext = CmpW'(1);
              end
              ramp_nxt = n_ext[RW-1:0];
              if (n_ext >= CmpW'(fade_up_r)) begin
                mode_nxt = MODE_OFF;
                act      = ACT_PASS;
              end else begin
                mode_nxt = MODE_UP;
                act      = ACT_SCALE;
                d_num    = n_ext[NW-1:0];
              end
            end
          end
          MODE_DOWN: begin
            d_den = fade_down_r;
            if (ramp_r <= RW'(1)) begin
              mode_nxt = MODE_DOWN_DEAD;
              ramp_nxt = '0;
            end else begin
              ramp_nxt = ramp_r - RW'(1);
              d_num    = NW'(ramp_r - RW'(1));
              act      = (fade_down_r == '0) ? ACT_ZERO : ACT_SCALE;
            end
          end
          default: begin
            mode_nxt = MODE_DOWN_DEAD;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && is_sample) begin
          state_nxt = (act == ACT_SCALE) ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        if (mul_last) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE:  in_stall = 1'b0;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_up_r   <= CFG_W'(2048);
      fade_down_r <= CFG_W'(2048);
      silent_r    <= '0;
      hold_r      <= 1'b1;
      state_r     <= S_IDLE;
      mode_r      <= MODE_DOWN_DEAD;
      ramp_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_FADE_UP:   fade_up_r   <= cfg_wdata;
          REG_FADE_DOWN: fade_down_r <= cfg_wdata;
          REG_SILENT:    silent_r    <= cfg_wdata;
          REG_HOLD:      hold_r      <= cfg_wdata[0];
          default:       hold_r      <= hold_r;
        endcase
      end
      state_r <= state_nxt;
      if (in_acc) begin
        mode_r <= mode_nxt;
        ramp_r <= ramp_nxt;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r != state_nxt || in_acc) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + CntW'(1);
      end
    end
  end

  // datapath, both lanes
  always_ff @(posedge clk) begin
    logic [SW:0]    sum;
    logic [CFG_W:0] trial;
    logic           big;
    for (int i = 0; i < 2; i++) begin
      sum   = '0;
      trial = '0;
      big   = 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            neg_r[i]  <= x_in[i][SW-1];
            mag_r[i]  <= x_in[i][SW-1] ? (~x_in[i] + SW'(1)) : x_in[i];
            prod_r[i] <= PW'(d_num);
            rem_r[i]  <= '0;
            res_r[i]  <= (act == ACT_PASS) ? x_in[i] : '0;
          end
        end
        S_MUL: begin
          // LSB-first shift-add: high half accumulates, multiplier shifts out
          sum = {1'b0, prod_r[i][PW-1:NW]} + (prod_r[i][0] ? {1'b0, mag_r[i]} : '0);
          prod_r[i] <= {sum, prod_r[i][NW-1:1]};
        end
        S_DIV: begin
          trial = {rem_r[i], prod_r[i][PW-1]};
          if (trial >= {1'b0, den_r}) begin
            rem_r[i]  <= CFG_W'(trial - {1'b0, den_r});
            prod_r[i] <= {prod_r[i][PW-2:0], 1'b1};
          end else begin
            rem_r[i]  <= trial[CFG_W-1:0];
            prod_r[i] <= {prod_r[i][PW-2:0], 1'b0};
          end
        end
        S_FIN: begin
          big = |prod_r[i][PW-1:SW-1];
          if (!neg_r[i]) begin
            res_r[i] <= big ? {1'b0, {(SW-1){1'b1}}} : prod_r[i][SW-1:0];
          end else begin
            res_r[i] <= big ? {1'b1, {(SW-1){1'b0}}} : (~prod_r[i][SW-1:0] + SW'(1));
          end
        end
        default: begin
        end
      endcase
    end
    if (in_acc) begin
      den_r      <= d_den;
      res_mode_r <= mode_nxt;
    end
    if (state_r == S_DONE && out_free) begin
      out_l_r    <= res_r[0];
      out_r_r    <= res_r[1];
      out_mode_r <= res_mode_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_l_r;
  assign out_right_out = out_r_r;
  assign out_fade_mode = out_mode_r;

endmodule

/* bench/stereo_fade_ramp_mute_tb.sv */
`timescale 1ns / 100ps
// Testbench for stereo_fade_ramp_mute: directed fades, then random fade sequences with noise.
// A fade predictor checks every output beat. Random input gaps and receiver stalls.
// Depends on sfrm_pkg and the stereo_fade_ramp_mute RTL.
module stereo_fade_ramp_mute_tb;
  import sfrm_pkg::*;

  localparam int ITEM_TARGET  = 1800;
  localparam int SETTLE_TICKS = 100;
  localparam int CYCLE_LIMIT  = 2000000;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic [2:0]         mode;
  } fade_pair_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_func;
  logic signed [23:0] in_left_in;
  logic signed [23:0] in_right_in;
  logic               out_valid;
  logic               out_stall;
  logic signed [23:0] out_left_out;
  logic signed [23:0] out_right_out;
  logic [2:0]         out_fade_mode;

  // predictor state and shadow registers
  mode_t       cur_mode;
  logic [15:0] cur_ramp;
  int          cur_up;
  int          cur_down;
  int          cur_silent;
  logic        cur_hold;

  fade_pair_t pending_pairs[$];
  int         err_cnt;
  int         item_cnt;
  int         cycle_cnt;
  int         stall_left;
  bit         calm;

  stereo_fade_ramp_mute uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_left_in   (in_left_in),
    .in_right_in  (in_right_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_left_out (out_left_out),
    .out_right_out(out_right_out),
    .out_fade_mode(out_fade_mode)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stalls: mostly short, a few long
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(99) < 25) begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(50, 10) : $urandom_range(3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  always @(posedge clk) begin
    fade_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        note_error($sformatf("unexpected beat L=%0d R=%0d mode=%0d",
                             out_left_out, out_right_out, out_fade_mode));
      end else begin
        want = pending_pairs.pop_front();
        if (want.left !== out_left_out || want.right !== out_right_out ||
            want.mode !== out_fade_mode)
          note_error($sformatf("expected L=%0d R=%0d mode=%0d, got L=%0d R=%0d mode=%0d",
                               want.left, want.right, want.mode,
                               out_left_out, out_right_out, out_fade_mode));
      end
    end
  end

  function automatic longint ramp_gain(input longint x, input longint num, input longint den);
    if (den == 0) return 0;
    return (x * num) / den;
  endfunction

  function automatic logic signed [23:0] clip24(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return 24'(v);
  endfunction

  task automatic fade_predict(input func_t f, input logic signed [23:0] li,
                              input logic signed [23:0] ri);
    longint     l;
    longint     r;
    int         n;
    fade_pair_t e;
    l = longint'(li);
    r = longint'(ri);
    case (f)
      FUNC_FADE_UP: begin
        if (!cur_hold && (cur_mode == MODE_DOWN || cur_mode == MODE_DOWN_DEAD)) begin
          cur_ramp = '0;
          cur_mode = MODE_UP_DEAD;
        end
      end
      FUNC_FADE_DOWN: begin
        if (cur_mode != MODE_DOWN && cur_mode != MODE_DOWN_DEAD) begin
          n = (int'(cur_ramp) < cur_down) ? int'(cur_ramp) : cur_down;
          if (n == 0) begin
            cur_mode = MODE_DOWN_DEAD;
          end else begin
            cur_ramp = 16'(n);
            cur_mode = MODE_DOWN;
          end
        end
      end
      FUNC_SAMPLE: begin
        if (cur_mode == MODE_UP_DEAD) begin
          n = int'(cur_ramp) + 1;
          if (n > cur_silent) begin
            cur_mode = MODE_UP;
            cur_ramp = '0;
          end else begin
            cur_ramp = 16'(n);
            l = 0;
            r = 0;
          end
        end
        if (cur_mode == MODE_UP) begin
          n = int'(cur_ramp) + 1;
          cur_ramp = 16'(n);
          if (n >= cur_up) begin
            cur_mode = MODE_OFF;
          end else begin
            l = ramp_gain(l, longint'(n), longint'(cur_up));
            r = ramp_gain(r, longint'(n), longint'(cur_up));
          end
        end else if (cur_mode == MODE_DOWN) begin
          if (cur_ramp <= 16'd1) begin
            cur_mode = MODE_DOWN_DEAD;
            cur_ramp = '0;
            l = 0;
            r = 0;
          end else begin
            n = int'(cur_ramp) - 1;
            cur_ramp = 16'(n);
            l = ramp_gain(l, longint'(n), longint'(cur_down));
            r = ramp_gain(r, longint'(n), longint'(cur_down));
          end
        end else if (cur_mode != MODE_OFF && cur_mode != MODE_UP_DEAD) begin
          cur_mode = MODE_DOWN_DEAD;
          l = 0;
          r = 0;
        end
        e.left  = clip24(l);
        e.right = clip24(r);
        e.mode  = cur_mode;
        pending_pairs.insert(pending_pairs.size(), e);
      end
      default: ;
    endcase
  endtask

  function automatic int idle_len();
    int pick;
    if (calm) return 0;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic signed [23:0] rand_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) return 24'sh7FFFFF;
    if (pick < 8) return 24'sh800000;
    if (pick < 10) return -24'sd1;
    if (pick < 12) return 24'sd0;
    if (pick < 30) return 24'(int'($urandom_range(1023)) - 512);
    return 24'($urandom);
  endfunction

  task automatic send_beat(input func_t f, input logic signed [23:0] l,
                           input logic signed [23:0] r);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= f;
    in_left_in  <= l;
    in_right_in <= r;
    fade_predict(f, l, r);
    item_cnt++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FADE_UP:   cur_up = int'(data);
      REG_FADE_DOWN: cur_down = int'(data);
      REG_SILENT:    cur_silent = int'(data);
      REG_HOLD:      cur_hold = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_muted_after_reset();
    send_beat(FUNC_SAMPLE, 24'sh7FFFFF, 24'sh800000);
    send_beat(FUNC_FADE_UP, 24'sd0, 24'sd0);
    send_beat(FUNC_NONE, 24'sh555555, 24'shAAAAAA);
    send_beat(FUNC_SAMPLE, -24'sd1, 24'sd1);
  endtask

  task automatic test_fade_cycle();
    settle();
    write_reg(REG_HOLD, 16'd0);
    write_reg(REG_FADE_UP, 16'd4);
    write_reg(REG_FADE_DOWN, 16'd3);
    write_reg(REG_SILENT, 16'd2);
    send_beat(FUNC_FADE_UP, 24'sd0, 24'sd0);
    send_beat(FUNC_SAMPLE, 24'sh7FFFFF, 24'sh800000);
    send_beat(FUNC_SAMPLE, 24'sh7FFFFF, 24'sh800000);
    send_beat(FUNC_SAMPLE, 24'sh7FFFFF, 24'sh800000);
    send_beat(FUNC_SAMPLE, 24'sh800000, -24'sd7);
    send_beat(FUNC_FADE_UP, 24'sd0, 24'sd0);
    send_beat(FUNC_SAMPLE, 24'sh7FFFFF, 24'sd5);
    send_beat(FUNC_SAMPLE, 24'sh400001, 24'sh800000);
    send_beat(FUNC_FADE_DOWN, 24'sd0, 24'sd0);
    send_beat(FUNC_FADE_DOWN, 24'sd0, 24'sd0);
    repeat (3) send_beat(FUNC_SAMPLE, 24'sh7FFFFF, 24'sh800000);
  endtask

  task automatic test_ramp_edges();
    settle();
    write_reg(REG_FADE_UP, 16'd3);
    write_reg(REG_FADE_DOWN, 16'd8);
    write_reg(REG_SILENT, 16'd0);
    send_beat(FUNC_FADE_UP, 24'sd0, 24'sd0);
    repeat (3) send_beat(FUNC_SAMPLE, 24'sh7FFFFF, 24'sh800000);
    send_beat(FUNC_FADE_DOWN, 24'sd0, 24'sd0);
    // gain above unity once the down ramp is shortened under the count
    settle();
    write_reg(REG_FADE_DOWN, 16'd1);
    send_beat(FUNC_SAMPLE, 24'sh7FFFFF, 24'sh800000);
    settle();
    write_reg(REG_FADE_DOWN, 16'd0);
    send_beat(FUNC_SAMPLE, 24'sh7FFFFF, 24'sh800000);
    settle();
    write_reg(REG_FADE_UP, 16'd0);
    send_beat(FUNC_FADE_UP, 24'sd0, 24'sd0);
    send_beat(FUNC_SAMPLE, 24'sh123456, 24'shFEDCBA);
  endtask

  function automatic logic [15:0] pick_steps();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return 16'd0;
    if (pick < 10) return 16'd1;
    if (pick < 14) return 16'hFFFF;
    if (pick < 20) return 16'($urandom);
    return 16'($urandom_range(24, 2));
  endfunction

  function automatic logic [15:0] pick_lead();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) return 16'd0;
    if (pick < 34) return 16'hFFFF;
    if (pick < 40) return 16'($urandom);
    return 16'($urandom_range(12));
  endfunction

  task automatic test_random_fades();
    int          phase_end;
    int          k;
    logic [15:0] hold_word;
    while (item_cnt < ITEM_TARGET) begin
      settle();
      calm = ($urandom_range(4) == 0);
      hold_word = (16'($urandom) & 16'hFFFE) | 16'($urandom_range(6) == 0);
      write_reg(REG_FADE_UP, pick_steps());
      write_reg(REG_FADE_DOWN, pick_steps());
      write_reg(REG_SILENT, pick_lead());
      write_reg(REG_HOLD, hold_word);
      phase_end = item_cnt + $urandom_range(120, 60);
      while (item_cnt < phase_end) begin
        if ($urandom_range(9) < 7) begin
          send_beat(FUNC_FADE_UP, rand_sample(), rand_sample());
          k = cur_silent + cur_up + $urandom_range(4);
          if (k > 48) k = 48;
          if ($urandom_range(3) == 0) k = $urandom_range(k);
          repeat (k) send_beat(FUNC_SAMPLE, rand_sample(), rand_sample());
          send_beat(FUNC_FADE_DOWN, rand_sample(), rand_sample());
          k = cur_down + $urandom_range(4);
          if (k > 48) k = 48;
          if ($urandom_range(3) == 0) k = $urandom_range(k);
          repeat (k) send_beat(FUNC_SAMPLE, rand_sample(), rand_sample());
        end else begin
          repeat ($urandom_range(6, 1))
            send_beat(func_t'($urandom_range(3)), rand_sample(), rand_sample());
        end
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_FADE_UP;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_func     = FUNC_SAMPLE;
    in_left_in  = '0;
    in_right_in = '0;
    out_stall   = 1'b0;
    stall_left  = 0;
    calm        = 1'b0;
    err_cnt     = 0;
    item_cnt    = 0;
    cycle_cnt   = 0;
    cur_mode    = MODE_DOWN_DEAD;
    cur_ramp    = '0;
    cur_up      = 2048;
    cur_down    = 2048;
    cur_silent  = 0;
    cur_hold    = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_muted_after_reset();
    test_fade_cycle();
    test_ramp_edges();
    test_random_fades();
    settle();

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
